FILE: hdl/neighbor_score_table_assert.svh
// Assertion macros for the neighbour score table.
// Each check is a clocked implication that is switched off while reset is low.
`ifndef NEIGHBOR_SCORE_TABLE_ASSERT_SVH
`define NEIGHBOR_SCORE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define NST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nst check failed");
// Consequent must hold in the cycle after the antecedent.
`define NST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nst check failed");
`else
`define NST_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/nst_pkg.sv
`default_nettype none

package nst_pkg;

    localparam int NST_MAX_NEIGHBORS = 64;

    localparam int ID_W      = 31;
    localparam int SCORE_W   = 17;
    localparam int COUNT_W   = 7;
    localparam int IN_DATA_W = 48;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 16;

    // 1.0 in unsigned Q1.16.
    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2,
        ST_PRESENT = 2'd3
    } t_status;

    // One stored neighbour.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_entry;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;    // start of a new command: forget the previous scan
        logic valid;    // read data from the entry memory is present
        logic last;     // the present entry is the highest occupied slot
    } t_scan_ctl;

endpackage

`default_nettype wire

FILE: hdl/nst_ram.sv
`default_nettype none

module nst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/nst_scan.sv
`default_nettype none

// Compare unit shared by every command: one stored entry per cycle is checked
// against the key and against the threshold, and the findings are kept.
module nst_scan
    import nst_pkg::*;
#(
    parameter int MAX_NEIGHBORS = NST_MAX_NEIGHBORS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire t_scan_ctl                            i_ctl,
    input  wire logic [$clog2(MAX_NEIGHBORS)-1:0]     i_slot,
    input  wire t_entry                               i_entry,
    input  wire logic [ID_W-1:0]                      i_key,
    input  wire logic [SCORE_W-1:0]                   i_thr,
    output logic                                      o_found,
    output logic      [$clog2(MAX_NEIGHBORS)-1:0]     o_slot,
    output logic      [SCORE_W-1:0]                   o_old_score,
    output t_entry                                    o_last_entry,
    output logic      [$clog2(MAX_NEIGHBORS+1)-1:0]   o_count
);

    localparam int AW = $clog2(MAX_NEIGHBORS);
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);

    logic          r_found;
    logic [AW-1:0] r_slot;
    logic [SCORE_W-1:0] r_old_score;
    t_entry        r_last_entry;
    logic [CW-1:0] r_count;

    logic hit;
    logic above;

    assign hit   = i_ctl.valid && !r_found && (i_entry.id == i_key);
    assign above = i_entry.score >= i_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
            r_count <= '0;
        end else if (i_ctl.valid) begin
            if (hit) begin
                r_found <= 1'b1;
            end
            if (above) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_slot      <= i_slot;
            r_old_score <= i_entry.score;
        end
        if (i_ctl.valid && i_ctl.last) begin
            r_last_entry <= i_entry;
        end
    end

    assign o_found      = r_found;
    assign o_slot       = r_slot;
    assign o_old_score  = r_old_score;
    assign o_last_entry = r_last_entry;
    assign o_count      = r_count;

endmodule

`default_nettype wire

FILE: hdl/neighbor_score_table.sv
// Channel   Direction  Handshake                    Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser: command; tdata: id, score
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: status, entry_count, above_count
// cfg       in         i_cfg_valid/o_cfg_ready          similarity_threshold
//
// A command is not accepted until the previous one has been handed to the output
// register. The single read port of the entry memory delivers one entry per cycle
// to the shared compare unit during the sweep, which is followed by an update
// step and a result step.
// Reset is synchronous and active low; it empties the table and clears the
// threshold at once. The entry memory itself is never cleared, since only slots
// below the fill level are ever read. A finished result waits in the output
// register; a new command is accepted meanwhile, and its result waits for that
// register to drain.
`default_nettype none

`include "neighbor_score_table_assert.svh"

module neighbor_score_table
    import nst_pkg::*;
#(
    parameter int MAX_NEIGHBORS = NST_MAX_NEIGHBORS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Command words.
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // neighbor_id[30:0], score[47:31]
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,  // command[1:0]
    // Result words.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,  // status[1:0], entry_count[8:2],
                                                        // above_count[15:9]
    // Threshold register.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [SCORE_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_NEIGHBORS);
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);

    // Sequencer states: wait for a command, sweep the table, apply the change,
    // then hand the result to the output register.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Command being worked on; the score is saturated to 1.0 on entry.
    t_cmd               r_cmd;
    logic [ID_W-1:0]    r_id;
    logic [SCORE_W-1:0] r_score;

    logic [SCORE_W-1:0] r_thr;
    logic [CW-1:0]      r_fill;

    // Sweep address, and the read that is in flight through the memory.
    logic [CW-1:0] r_addr;
    logic          r_rd_vld;
    logic          r_rd_last;
    logic [AW-1:0] r_rd_slot;

    // Result waiting between the update cycle and the output register.
    t_status       r_res_status;
    logic [CW-1:0] r_res_fill;
    logic [CW-1:0] r_res_above;

    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;

    logic               in_accept;
    logic [SCORE_W-1:0] in_score;
    logic               rd_en;
    t_entry             rd_data;
    t_scan_ctl          scan_ctl;

    logic               sc_found;
    logic [AW-1:0]      sc_slot;
    logic [SCORE_W-1:0] sc_old_score;
    t_entry             sc_last_entry;
    logic [CW-1:0]      sc_count;

    logic               ge_new;
    logic               ge_old;
    t_status            a_status;
    logic [CW-1:0]      a_fill;
    logic [CW-1:0]      a_above;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;
    logic               out_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // Commands are taken only while the sequencer is waiting; the output
    // register is free to hold the previous result at that time.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign in_score = (i_s_axis_tdata[IN_DATA_W-1:ID_W] > SCORE_ONE) ?
                      SCORE_ONE : i_s_axis_tdata[IN_DATA_W-1:ID_W];

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= t_cmd'(i_s_axis_tuser);
            r_id    <= i_s_axis_tdata[ID_W-1:0];
            r_score <= in_score;
        end
    end

    // The sweep reads every occupied slot once. A read issued in one cycle
    // reaches the compare unit in the next, so the sweep ends in the cycle after
    // the last address has gone out.
    assign rd_en = (r_state == S_SCAN) && (r_addr < r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + CW'(1);
        end
        r_rd_last <= (r_addr == r_fill - CW'(1));
        r_rd_slot <= r_addr[AW-1:0];
    end

    assign scan_ctl.clear = in_accept;
    assign scan_ctl.valid = r_rd_vld;
    assign scan_ctl.last  = r_rd_last;

    nst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_NEIGHBORS)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    nst_scan #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_slot       (r_rd_slot),
        .i_entry      (rd_data),
        .i_key        (r_id),
        .i_thr        (r_thr),
        .o_found      (sc_found),
        .o_slot       (sc_slot),
        .o_old_score  (sc_old_score),
        .o_last_entry (sc_last_entry),
        .o_count      (sc_count)
    );

    // The sweep counted the table as it stood before the command. The update
    // cycle corrects that count for the one entry the command changes: a new
    // score is added, a replaced or removed score is taken away. On a delete
    // the entry moved down from the top slot keeps its score, so it stays
    // counted.
    assign ge_new = r_score >= r_thr;
    assign ge_old = sc_old_score >= r_thr;

    always_comb begin
        a_status = ST_OK;
        a_fill   = r_fill;
        a_above  = sc_count;
        wr_en    = 1'b0;
        wr_addr  = sc_slot;
        wr_data  = '{id: r_id, score: r_score};
        case (r_cmd)
            CMD_INSERT: begin
                if (sc_found) begin
                    a_status = ST_PRESENT;
                end else if (r_fill == CW'(MAX_NEIGHBORS)) begin
                    a_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_fill[AW-1:0];
                    a_fill  = r_fill + CW'(1);
                    a_above = sc_count + CW'(ge_new);
                end
            end
            CMD_UPDATE: begin
                if (!sc_found) begin
                    a_status = ST_UNKNOWN;
                end else begin
                    wr_en   = 1'b1;
                    a_above = sc_count + CW'(ge_new) - CW'(ge_old);
                end
            end
            CMD_DELETE: begin
                if (!sc_found) begin
                    a_status = ST_UNKNOWN;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = sc_last_entry;
                    a_fill  = r_fill - CW'(1);
                    a_above = sc_count - CW'(ge_old);
                end
            end
            default: begin
                a_status = ST_OK;
            end
        endcase
        if (r_state != S_APPLY) begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (r_state == S_APPLY) begin
            r_fill <= a_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_res_status <= a_status;
            r_res_fill   <= a_fill;
            r_res_above  <= a_above;
        end
    end

    // The result moves on once the previous word has left or is leaving.
    assign out_load = (r_state == S_DONE) && (!r_o_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == r_fill) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_data <= {COUNT_W'(r_res_above), COUNT_W'(r_res_fill), r_res_status};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    // A command always starts its sweep at slot zero.
    `NST_ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, in_accept,
        (r_state == S_SCAN) && (r_addr == '0))
    // Memory read data only arrives while the table is being swept.
    `NST_ASSERT_NOW(a_read_in_scan, i_clk, i_rst_n, r_rd_vld, r_state == S_SCAN)
    // The corrected count can never exceed the number of stored entries.
    `NST_ASSERT_NOW(a_above_bound, i_clk, i_rst_n, r_state == S_APPLY,
        (a_above <= a_fill) && (a_fill <= CW'(MAX_NEIGHBORS)))
    // A successful insert grows the table by exactly one entry.
    `NST_ASSERT_NEXT(a_insert_grow, i_clk, i_rst_n,
        (r_state == S_APPLY) && (r_cmd == CMD_INSERT) && (a_status == ST_OK),
        r_fill == $past(r_fill) + CW'(1))

endmodule

`default_nettype wire

FILE: test/neighbor_score_table_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module neighbor_score_table_checker
    import nst_pkg::*;
#(
    parameter int MAX_NEIGHBORS = NST_MAX_NEIGHBORS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    input  wire logic                  i_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // neighbor_id[30:0], score[47:31]
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,  // command[1:0]
    input  wire logic                  i_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_axis_tdata,  // status[1:0], entry_count[8:2],
                                                        // above_count[15:9]
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [SCORE_W-1:0]    i_cfg_data,
    output int                         o_failures,
    output int                         o_outstanding
);

    // Packed so that it lines up with the result word, status in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] above_count;
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
    } t_table_reply;

    logic [ID_W-1:0]    held_ids    [MAX_NEIGHBORS];
    logic [SCORE_W-1:0] held_scores [MAX_NEIGHBORS];
    int                 held_count;
    logic [SCORE_W-1:0] threshold;
    t_table_reply       replies_due [$];
    int                 fail_tally = 0;

    function automatic int slot_of(logic [ID_W-1:0] id);
        for (int i = 0; i < held_count; i++) begin
            if (held_ids[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command to the shadow table and returns the reply it earns.
    function automatic t_table_reply run_command(t_cmd cmd, logic [ID_W-1:0] id,
                                                 logic [SCORE_W-1:0] score);
        t_table_reply       reply;
        logic [SCORE_W-1:0] clipped;
        int                 slot;
        int                 above;
        clipped = (score > SCORE_ONE) ? SCORE_ONE : score;
        reply.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (slot_of(id) >= 0) begin
                    reply.status = ST_PRESENT;
                end else if (held_count >= MAX_NEIGHBORS) begin
                    reply.status = ST_FULL;
                end else begin
                    held_ids[held_count]    = id;
                    held_scores[held_count] = clipped;
                    held_count++;
                end
            end
            CMD_UPDATE: begin
                slot = slot_of(id);
                if (slot < 0) begin
                    reply.status = ST_UNKNOWN;
                end else begin
                    held_scores[slot] = clipped;
                end
            end
            CMD_DELETE: begin
                slot = slot_of(id);
                if (slot < 0) begin
                    reply.status = ST_UNKNOWN;
                end else begin
                    held_ids[slot]    = held_ids[held_count-1];
                    held_scores[slot] = held_scores[held_count-1];
                    held_count--;
                end
            end
            default: begin
            end
        endcase
        above = 0;
        for (int i = 0; i < held_count; i++) begin
            if (held_scores[i] >= threshold) begin
                above++;
            end
        end
        reply.entry_count = held_count[COUNT_W-1:0];
        reply.above_count = above[COUNT_W-1:0];
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_table_reply got;
        t_table_reply want;
        t_table_reply fresh;
        if (!i_rst_n) begin
            held_count = 0;
            threshold  = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                threshold = i_cfg_data;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                fresh = run_command(t_cmd'(i_s_axis_tuser),
                                    i_s_axis_tdata[ID_W-1:0],
                                    i_s_axis_tdata[ID_W +: SCORE_W]);
                replies_due = {replies_due, fresh};
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (replies_due.size() == 0) begin
                    fail_tally++;
                    $display("%0t: result word with none outstanding: expected none, actual %h",
                             $time, got);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status != want.status) begin
                        fail_tally++;
                        $display("%0t: status: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.entry_count != want.entry_count) begin
                        fail_tally++;
                        $display("%0t: entry_count: expected %0d, actual %0d",
                                 $time, want.entry_count, got.entry_count);
                    end
                    if (got.above_count != want.above_count) begin
                        fail_tally++;
                        $display("%0t: above_count: expected %0d, actual %0d",
                                 $time, want.above_count, got.above_count);
                    end
                end
            end
        end
        o_failures    <= fail_tally;
        o_outstanding <= replies_due.size();
    end

endmodule

`default_nettype wire

FILE: test/neighbor_score_table_test.sv
`timescale 1ns / 1ps
`default_nettype none

// Stimulus and verdict for the neighbour score table. The checker beside the
// block keeps its own copy of the table, predicts each result word and counts
// mismatches; this module only produces command words, threshold writes and
// back-pressure, and reports the outcome at the end.
module neighbor_score_table_test;
    import nst_pkg::*;

    localparam int POOL_SIZE = 96;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [SCORE_W-1:0]    i_cfg_data;
    int                    failures;
    int                    outstanding;

    // While set, neither the sender nor the receiver inserts any idle cycle.
    logic                  steady = 1'b0;
    logic [SCORE_W-1:0]    threshold_now;
    // Neighbour identifiers that the random part draws from. The pool is a little
    // larger than the table, so that it fills up, overflows and drains again.
    logic [ID_W-1:0]       id_pool [POOL_SIZE];

    neighbor_score_table uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    neighbor_score_table_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_failures      (failures),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // The receiver stalls at random about thirty percent of the time, except during the
    // steady stretch, when it takes every result word at once.
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(99) >= 30);
    end

    // Offers one command word and returns once the block has taken it. A run of
    // idle cycles may come first; valid is only ever given one value per edge.
    task automatic issue(t_cmd cmd, logic [ID_W-1:0] id, logic [SCORE_W-1:0] score);
        if (!steady) begin
            while ($urandom_range(99) < 30) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {score, id};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Waits until every result word that the checker expects has come out. The
    // first edge lets the count catch up with a word accepted at this very edge.
    task automatic await_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The threshold is only changed while the block is idle. Every command gives
    // a result word, so once the last one is out the block has nothing in hand;
    // a short pause is kept all the same.
    task automatic set_threshold(logic [SCORE_W-1:0] value);
        await_drain();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid   <= 1'b0;
        threshold_now = value;
    endtask

    // Scores lean towards the interesting values: zero, one and just below it,
    // values past one that must saturate, and values right around the threshold.
    function automatic logic [SCORE_W-1:0] pick_score();
        logic [SCORE_W-1:0] value;
        case ($urandom_range(7))
            0: value = '0;
            1: value = SCORE_ONE;
            2: value = SCORE_ONE - 1;
            3: value = SCORE_W'($urandom_range(131071, 65537));
            4: value = threshold_now + SCORE_W'($urandom_range(2)) - SCORE_W'(1);
            default: value = SCORE_W'($urandom_range(65536));
        endcase
        return value;
    endfunction

    // A phase of random commands. Most identifiers come from the pool, so that
    // updates and deletes usually hit a stored neighbour; the rest are fresh
    // random identifiers that almost always miss.
    task automatic run_phase(int items, int insert_pct, int delete_pct);
        int              pick;
        t_cmd            cmd;
        logic [ID_W-1:0] id;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            if (pick < insert_pct) begin
                cmd = CMD_INSERT;
            end else if (pick < insert_pct + delete_pct) begin
                cmd = CMD_DELETE;
            end else if (pick < insert_pct + delete_pct + 15) begin
                cmd = CMD_UPDATE;
            end else begin
                cmd = CMD_QUERY;
            end
            if ($urandom_range(99) < 90) begin
                id = id_pool[$urandom_range(POOL_SIZE-1)];
            end else begin
                id = ID_W'($urandom());
            end
            issue(cmd, id, pick_score());
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_QUERY;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        threshold_now   = '0;

        // The pool holds both identifier extremes, random identifiers, and
        // partners that differ from an earlier one in a single bit, so that a
        // compare which ignores any bit gets caught.
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            if (i < 48) begin
                id_pool[i] = ID_W'($urandom());
            end else begin
                id_pool[i] = id_pool[i-46] ^ (31'd1 << (i % ID_W));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the threshold at one half.
        set_threshold(17'h08000);
        issue(CMD_QUERY,  31'd5, 17'd0);            // query of an empty table
        issue(CMD_DELETE, 31'd5, 17'd0);            // delete of an absent neighbour
        issue(CMD_UPDATE, 31'd5, 17'd100);          // update of an absent neighbour
        issue(CMD_INSERT, 31'h0000_0000, 17'h00000);
        issue(CMD_INSERT, 31'h7FFF_FFFF, 17'h1FFFF);  // saturates to one
        issue(CMD_INSERT, 31'h2AAA_AAAA, 17'h08000);  // exactly at the threshold
        issue(CMD_INSERT, 31'h5555_5555, 17'h07FFF);  // just below it
        issue(CMD_INSERT, 31'h0000_0000, 17'h10000);  // duplicate insert
        issue(CMD_UPDATE, 31'h5555_5555, 17'h10000);
        issue(CMD_UPDATE, 31'h0000_0000, 17'h10001);  // saturating update
        issue(CMD_QUERY,  31'h7FFF_FFFF, 17'h1FFFF);  // query ignores its fields
        issue(CMD_DELETE, 31'h5555_5555, 17'd0);      // the last entry is dropped
        issue(CMD_DELETE, 31'h0000_0000, 17'd0);      // the last entry fills the hole
        issue(CMD_UPDATE, 31'h7FFF_FFFF, 17'h07FFF);
        issue(CMD_QUERY,  31'd0, 17'd0);
        issue(CMD_DELETE, 31'h2AAA_AAAA, 17'd0);
        issue(CMD_DELETE, 31'h7FFF_FFFF, 17'd0);      // table empty again
        issue(CMD_DELETE, 31'h7FFF_FFFF, 17'd0);      // now absent
        issue(CMD_INSERT, 31'h7FFF_FFFE, 17'h10000);

        // Random part: the table is driven alternately towards full, where
        // inserts are refused, and back towards empty. Each phase runs with its
        // own threshold, the extremes and the value past one among them.
        set_threshold(17'h10000);
        run_phase(240, 75, 5);
        set_threshold(17'h00000);
        run_phase(240, 20, 55);
        set_threshold(17'h1FFFF);
        run_phase(240, 70, 10);
        set_threshold(17'h10001);
        run_phase(240, 30, 40);
        set_threshold(17'h00001);
        steady = 1'b1;
        run_phase(240, 60, 15);
        steady = 1'b0;
        set_threshold(17'h08000);
        run_phase(240, 25, 50);
        set_threshold(SCORE_W'($urandom_range(65536)));
        run_phase(240, 75, 5);
        set_threshold(17'h0FFFF);
        run_phase(240, 40, 35);

        // Let every result word out, then allow for the longest command before
        // giving the verdict.
        await_drain();
        repeat (80) @(posedge i_clk);
        if (failures == 0 && outstanding == 0) begin
            $display("** neighbor_score_table: PASSED **");
        end else begin
            $display("** neighbor_score_table: FAILED **");
        end
        $finish;
    end

    // A timeout well beyond the length of a correct run; this stops a hung handshake.
    initial begin
        #10_000_000;
        $display("** neighbor_score_table: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
